// ===== sv/scba_pkg.sv =====
// Shared types, constants and class functions for the size class block allocator.
package scba_pkg;

	localparam int unsigned CHUNK_BYTES   = 1048576;
	localparam int unsigned ARENA_CHUNKS  = 4;
	localparam int unsigned GRANULE_BYTES = 16;
	localparam int unsigned CLASS_COUNT   = 39;
	localparam int unsigned LINEAR_COUNT  = 32;
	localparam int unsigned LINEAR_LIMIT  = 512;
	localparam int unsigned FIRST_POWER   = 1024;
	localparam int unsigned MAX_BLOCK     = 65536;

	localparam int unsigned ARENA_BYTES = ARENA_CHUNKS * CHUNK_BYTES;
	localparam int unsigned ARENA_LG    = $clog2(ARENA_BYTES);
	localparam int unsigned CHUNK_LG    = $clog2(CHUNK_BYTES);
	localparam int unsigned GRAN_LG     = $clog2(GRANULE_BYTES);
	localparam int unsigned SLOT_W      = ARENA_LG - GRAN_LG;
	localparam int unsigned SLOT_COUNT  = ARENA_BYTES / GRANULE_BYTES;
	localparam int unsigned CLASS_W     = $clog2(CLASS_COUNT);
	localparam int unsigned SIZE_W      = 17;
	localparam int unsigned CUR_W       = ARENA_LG + 1;
	localparam int unsigned NCH_W       = $clog2(ARENA_CHUNKS + 1);

	localparam logic [2:0] FN_ALLOC   = 3'd0;
	localparam logic [2:0] FN_FREE    = 3'd1;
	localparam logic [2:0] FN_SIZE    = 3'd2;
	localparam logic [2:0] FN_CAP     = 3'd3;
	localparam logic [2:0] FN_REALLOC = 3'd4;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_NOSPACE = 3'd1;
	localparam logic [2:0] ST_NOBLOCK = 3'd2;
	localparam logic [2:0] ST_TOOBIG  = 3'd3;
	localparam logic [2:0] ST_REFUSED = 3'd4;

	localparam logic [1:0] CFG_BASE    = 2'd0;
	localparam logic [1:0] CFG_ZERO    = 2'd1;
	localparam logic [1:0] CFG_NOREUSE = 2'd2;

	typedef struct packed {
		logic              valid;
		logic [SIZE_W-1:0] req;
		logic [CLASS_W-1:0] cls;
		logic [SLOT_W-1:0] next;
	} rec_t;

	typedef struct packed {
		logic [SLOT_W-1:0] head;
		logic [SLOT_W-1:0] tail;
	} lst_t;

	typedef enum logic [8:0] {
		S_CLR   = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_DEC   = 9'b000000100,
		S_EVAL  = 9'b000001000,
		S_ALLOC = 9'b000010000,
		S_POP   = 9'b000100000,
		S_KILL  = 9'b001000000,
		S_FREE  = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

	typedef struct packed {
		logic clear;
		logic accept;
		logic dec;
		logic eval;
		logic alloc;
		logic pop;
		logic kill;
		logic free;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic ev_alloc;
		logic ev_kill;
		logic al_pop;
		logic al_more;
		logic kl_free;
	} sts_t;

	function automatic logic [CLASS_W-1:0] class_of(input logic [31:0] sz);
		logic [31:0] m1;
		logic [CLASS_W-1:0] c;
		m1 = sz - 32'd1;
		c = CLASS_W'(CLASS_COUNT - 1);
		if (sz <= 32'(LINEAR_LIMIT)) begin
			c = (sz == 32'd0) ? '0 : CLASS_W'(m1 >> GRAN_LG);
		end else begin
			for (int k = CLASS_COUNT - LINEAR_COUNT - 1; k >= 0; k--) begin
				if (sz <= (32'(FIRST_POWER) << k))
					c = CLASS_W'(LINEAR_COUNT + k);
			end
		end
		return c;
	endfunction

	function automatic logic [SIZE_W-1:0] class_bytes(input logic [CLASS_W-1:0] c);
		logic [SIZE_W-1:0] b;
		logic [CLASS_W-1:0] k;
		k = c - CLASS_W'(LINEAR_COUNT);
		if (c < CLASS_W'(LINEAR_COUNT))
			b = (SIZE_W'(c) + SIZE_W'(1)) << GRAN_LG;
		else
			b = SIZE_W'(FIRST_POWER) << k[2:0];
		return b;
	endfunction

endpackage

// ===== sv/scba_ctrl.sv =====
// Request sequencer for the allocator: state machine and output word valid.
module scba_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  scba_pkg::sts_t   sts,
	output scba_pkg::cmd_t   cmd
);

	scba_pkg::state_t state_q, state_d;
	logic out_valid_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		in_ready = 1'b0;
		case (state_q)
			scba_pkg::S_CLR: begin
				cmd.clear = 1'b1;
				if (sts.clr_last)
					state_d = scba_pkg::S_IDLE;
			end
			scba_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d = scba_pkg::S_DEC;
				end
			end
			scba_pkg::S_DEC: begin
				cmd.dec = 1'b1;
				state_d = scba_pkg::S_EVAL;
			end
			scba_pkg::S_EVAL: begin
				cmd.eval = 1'b1;
				if (sts.ev_alloc)
					state_d = scba_pkg::S_ALLOC;
				else if (sts.ev_kill)
					state_d = scba_pkg::S_KILL;
				else
					state_d = scba_pkg::S_DONE;
			end
			scba_pkg::S_ALLOC: begin
				cmd.alloc = 1'b1;
				if (sts.al_pop)
					state_d = scba_pkg::S_POP;
				else if (sts.al_more)
					state_d = scba_pkg::S_KILL;
				else
					state_d = scba_pkg::S_DONE;
			end
			scba_pkg::S_POP: begin
				cmd.pop = 1'b1;
				state_d = sts.al_more ? scba_pkg::S_KILL : scba_pkg::S_DONE;
			end
			scba_pkg::S_KILL: begin
				cmd.kill = 1'b1;
				state_d = sts.kl_free ? scba_pkg::S_FREE : scba_pkg::S_DONE;
			end
			scba_pkg::S_FREE: begin
				cmd.free = 1'b1;
				state_d = scba_pkg::S_DONE;
			end
			scba_pkg::S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load = 1'b1;
					state_d = scba_pkg::S_IDLE;
				end
			end
			default: state_d = scba_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scba_pkg::S_CLR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== sv/scba_dp.sv =====
// Allocator datapath: header slot memory, free-list memory, carve state and result words.
module scba_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  scba_pkg::cmd_t                cmd,
	output scba_pkg::sts_t                sts,
	input  logic                          wr_en,
	input  logic [1:0]                    wr_index,
	input  logic [31:0]                   wr_data,
	input  logic [2:0]                    func,
	input  logic [31:0]                   request_size,
	input  logic [31:0]                   block_address,
	input  logic                          zero_fill,
	input  logic                          in_place_only,
	output logic [2:0]                    status,
	output logic [31:0]                   result_address,
	output logic [scba_pkg::SIZE_W-1:0]   query_value,
	output logic [scba_pkg::SIZE_W-1:0]   fill_offset,
	output logic [scba_pkg::SIZE_W-1:0]   fill_length,
	output logic [scba_pkg::SIZE_W-1:0]   copy_length
);

	localparam int unsigned SW = scba_pkg::SLOT_W;
	localparam int unsigned CW = scba_pkg::CLASS_W;
	localparam int unsigned ZW = scba_pkg::SIZE_W;
	localparam int unsigned UW = scba_pkg::CUR_W;

	scba_pkg::rec_t slot_mem [scba_pkg::SLOT_COUNT];
	scba_pkg::lst_t list_mem [scba_pkg::CLASS_COUNT];
	scba_pkg::rec_t rec_rd;
	scba_pkg::lst_t lst_rd;

	logic [31:0] base_q;
	logic        zero_all_q, no_recycle_q;
	logic [scba_pkg::CLASS_COUNT-1:0] ne_q;
	logic [UW-1:0] cursor_q, limit_q;
	logic [scba_pkg::NCH_W-1:0] nch_q;
	logic [SW-1:0] clr_q;

	logic [2:0]  func_q;
	logic [31:0] size_q, addr_q;
	logic        zf_q, ipo_q, ok_q, mv_q;
	logic [SW-1:0] slot_q, newslot_q;
	logic [CW-1:0] cnew_q;
	scba_pkg::rec_t old_q;
	scba_pkg::lst_t lst_q;
	logic [2:0]  w_status;
	logic [31:0] w_res;
	logic [ZW-1:0] w_qv, w_foff, w_flen, w_clen;
	logic [2:0]  out_status_q;
	logic [31:0] out_res_q;
	logic [ZW-1:0] out_qv_q, out_foff_q, out_flen_q, out_clen_q;

	logic [31:0] off;
	logic        inrng;
	logic [SW-1:0] slot_idx;
	logic        found, fits, zero;
	logic [ZW-1:0] cap_old, cap_new;
	logic        too_big, use_list, pop_more, over, full, carve_fail, alloc_ok;
	logic [UW-1:0] need, cur_base;
	logic [SW-1:0] s_new, s_res;
	logic [31:0] res_addr;

	logic          s_we;
	logic [SW-1:0] s_wa, s_ra;
	scba_pkg::rec_t s_wd;
	logic          l_we;
	logic [CW-1:0] l_wa, l_ra;
	scba_pkg::lst_t l_wd;

	always_comb begin
		off = addr_q - base_q;
		inrng = (addr_q != 32'd0) && (off >= 32'(scba_pkg::GRANULE_BYTES)) &&
			(off[scba_pkg::GRAN_LG-1:0] == '0) && (off[31:scba_pkg::ARENA_LG] == '0);
		slot_idx = off[scba_pkg::ARENA_LG-1:scba_pkg::GRAN_LG] - SW'(1);
		found = ok_q && rec_rd.valid;
		cap_old = scba_pkg::class_bytes(rec_rd.cls);
		fits = size_q <= 32'(cap_old);
		zero = zf_q || zero_all_q;
		cap_new = scba_pkg::class_bytes(cnew_q);
		too_big = size_q > 32'(scba_pkg::MAX_BLOCK);
		use_list = !no_recycle_q && ne_q[cnew_q];
		pop_more = use_list && (lst_q.head != lst_q.tail);
		need = UW'(scba_pkg::GRANULE_BYTES) + UW'(cap_new);
		over = ({1'b0, cursor_q} + {1'b0, need}) > {1'b0, limit_q};
		full = nch_q >= scba_pkg::NCH_W'(scba_pkg::ARENA_CHUNKS);
		carve_fail = over && full;
		cur_base = over ? (UW'(nch_q) << scba_pkg::CHUNK_LG) : cursor_q;
		alloc_ok = !too_big && (use_list || !carve_fail);
		s_new = use_list ? lst_q.head : cur_base[scba_pkg::ARENA_LG-1:scba_pkg::GRAN_LG];
		s_res = cmd.pop ? newslot_q : s_new;
		res_addr = base_q + ((32'(s_res) + 32'd1) << scba_pkg::GRAN_LG);
	end

	always_comb begin
		sts.clr_last = &clr_q;
		sts.ev_alloc = (func_q == scba_pkg::FN_ALLOC) ||
			((func_q == scba_pkg::FN_REALLOC) &&
			 ((addr_q == 32'd0) || (found && !fits && !ipo_q)));
		sts.ev_kill = (func_q == scba_pkg::FN_FREE) && (addr_q != 32'd0) && found;
		sts.al_pop = !too_big && pop_more;
		sts.al_more = mv_q && (cmd.pop || (alloc_ok && !pop_more));
		sts.kl_free = !no_recycle_q;
	end

	always_comb begin
		s_we = 1'b0;
		s_wa = s_new;
		s_wd = '{valid: 1'b1, req: size_q[ZW-1:0], cls: cnew_q, next: '0};
		l_we = 1'b0;
		l_wa = cnew_q;
		l_wd = '{head: rec_rd.next, tail: lst_q.tail};
		if (cmd.clear) begin
			s_we = 1'b1;
			s_wa = clr_q;
			s_wd = '0;
		end else if (cmd.eval) begin
			s_we = (func_q == scba_pkg::FN_REALLOC) && (addr_q != 32'd0) && found && fits;
			s_wa = slot_q;
			s_wd = '{valid: 1'b1, req: size_q[ZW-1:0], cls: rec_rd.cls, next: rec_rd.next};
		end else if (cmd.alloc) begin
			s_we = alloc_ok && !pop_more;
		end else if (cmd.pop) begin
			s_we = 1'b1;
			s_wa = newslot_q;
			l_we = 1'b1;
		end else if (cmd.kill) begin
			s_we = 1'b1;
			s_wa = slot_q;
			s_wd = '{valid: 1'b0, req: old_q.req, cls: old_q.cls, next: '0};
		end else if (cmd.free) begin
			s_we = ne_q[old_q.cls];
			s_wa = lst_rd.tail;
			s_wd = '{valid: 1'b0, req: '0, cls: '0, next: slot_q};
			l_we = 1'b1;
			l_wa = old_q.cls;
			l_wd = '{head: ne_q[old_q.cls] ? lst_rd.head : slot_q, tail: slot_q};
		end
		s_ra = cmd.dec ? slot_idx : lst_q.head;
		l_ra = cmd.dec ? scba_pkg::class_of(size_q) : old_q.cls;
	end

	always_ff @(posedge clk) begin
		if (s_we)
			slot_mem[s_wa] <= s_wd;
		rec_rd <= slot_mem[s_ra];
	end

	always_ff @(posedge clk) begin
		if (l_we)
			list_mem[l_wa] <= l_wd;
		lst_rd <= list_mem[l_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			zero_all_q <= 1'b0;
			no_recycle_q <= 1'b0;
			ne_q <= '0;
			cursor_q <= '0;
			limit_q <= '0;
			nch_q <= '0;
			clr_q <= '0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					scba_pkg::CFG_BASE: base_q <= wr_data;
					scba_pkg::CFG_ZERO: zero_all_q <= wr_data[0];
					scba_pkg::CFG_NOREUSE: no_recycle_q <= wr_data[0];
					default: ;
				endcase
			end
			if (cmd.clear)
				clr_q <= clr_q + SW'(1);
			if (cmd.alloc && !too_big) begin
				if (use_list) begin
					if (!pop_more)
						ne_q[cnew_q] <= 1'b0;
				end else if (!carve_fail) begin
					cursor_q <= cur_base + need;
					if (over) begin
						limit_q <= cur_base + UW'(scba_pkg::CHUNK_BYTES);
						nch_q <= nch_q + scba_pkg::NCH_W'(1);
					end
				end
			end
			if (cmd.free)
				ne_q[old_q.cls] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q <= func;
			size_q <= request_size;
			addr_q <= block_address;
			zf_q <= zero_fill;
			ipo_q <= in_place_only;
		end
		if (cmd.dec) begin
			ok_q <= inrng;
			slot_q <= slot_idx;
			cnew_q <= scba_pkg::class_of(size_q);
			mv_q <= 1'b0;
			w_status <= scba_pkg::ST_OK;
			w_res <= '0;
			w_qv <= '0;
			w_foff <= '0;
			w_flen <= '0;
			w_clen <= '0;
		end
		if (cmd.eval) begin
			old_q <= rec_rd;
			lst_q <= lst_rd;
			mv_q <= (func_q == scba_pkg::FN_REALLOC) && (addr_q != 32'd0) &&
				found && !fits && !ipo_q;
			case (func_q)
				scba_pkg::FN_ALLOC: ;
				scba_pkg::FN_FREE: begin
					if (addr_q != 32'd0 && !found)
						w_status <= scba_pkg::ST_NOBLOCK;
				end
				scba_pkg::FN_SIZE, scba_pkg::FN_CAP: begin
					if (!found)
						w_status <= scba_pkg::ST_NOBLOCK;
					else
						w_qv <= (func_q == scba_pkg::FN_SIZE) ? rec_rd.req : cap_old;
				end
				scba_pkg::FN_REALLOC: begin
					if (addr_q != 32'd0) begin
						if (!found) begin
							w_status <= scba_pkg::ST_NOBLOCK;
						end else if (fits) begin
							w_res <= addr_q;
							if (zf_q && size_q[ZW-1:0] > rec_rd.req) begin
								w_foff <= rec_rd.req;
								w_flen <= size_q[ZW-1:0] - rec_rd.req;
							end
						end else if (ipo_q) begin
							w_status <= scba_pkg::ST_REFUSED;
						end
					end
				end
				default: w_status <= scba_pkg::ST_NOBLOCK;
			endcase
		end
		if (cmd.alloc) begin
			newslot_q <= s_new;
			if (too_big)
				w_status <= scba_pkg::ST_TOOBIG;
			else if (!alloc_ok)
				w_status <= scba_pkg::ST_NOSPACE;
		end
		if ((cmd.alloc && alloc_ok && !pop_more) || cmd.pop) begin
			w_res <= res_addr;
			w_flen <= zero ? cap_new : '0;
			w_clen <= mv_q ? old_q.req : '0;
		end
		if (cmd.load) begin
			out_status_q <= w_status;
			out_res_q <= w_res;
			out_qv_q <= w_qv;
			out_foff_q <= w_foff;
			out_flen_q <= w_flen;
			out_clen_q <= w_clen;
		end
	end

	assign status = out_status_q;
	assign result_address = out_res_q;
	assign query_value = out_qv_q;
	assign fill_offset = out_foff_q;
	assign fill_length = out_flen_q;
	assign copy_length = out_clen_q;

endmodule

// ===== sv/size_class_block_allocator.sv =====
// Top level of the size class block allocator.
// One request at a time. After reset the block clears all 262144 header slots, one per
// cycle, before in_ready rises. A request then runs from accept to result through
// decode, a registered read of the header slot and the free-list entry, then allocate,
// free-list pop, header kill and free-list push steps as needed, each bound by the single
// write port of the header memory. An allocate with a carve runs decode, evaluate and
// allocate; a moving reallocate with recycling can add pop, kill and push. The result
// word is held in an output register; the next request is taken the cycle after it has
// been loaded. A word not yet taken holds the next result in its last step.
module size_class_block_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  func,
	input  logic [31:0] request_size,
	input  logic [31:0] block_address,
	input  logic        zero_fill,
	input  logic        in_place_only,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [31:0] result_address,
	output logic [16:0] query_value,
	output logic [16:0] fill_offset,
	output logic [16:0] fill_length,
	output logic [16:0] copy_length,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [31:0] wr_data
);

	scba_pkg::cmd_t cmd;
	scba_pkg::sts_t sts;

	scba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	scba_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.wr_en          (wr_en),
		.wr_index       (wr_index),
		.wr_data        (wr_data),
		.func           (func),
		.request_size   (request_size),
		.block_address  (block_address),
		.zero_fill      (zero_fill),
		.in_place_only  (in_place_only),
		.status         (status),
		.result_address (result_address),
		.query_value    (query_value),
		.fill_offset    (fill_offset),
		.fill_length    (fill_length),
		.copy_length    (copy_length)
	);

	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != scba_pkg::ST_OK) |->
		(result_address == 32'd0 && fill_length == 17'd0 && copy_length == 17'd0))
		else $error("failed word carries an address or range");

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> !in_ready)
		else $error("request taken during clearing pass");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> out_valid)
		else $error("loaded word not presented");

endmodule
